[rtl/htt_pkg.sv]
// Shared types and constants for the Huffman tree-table decoder.
`timescale 1ns / 1ps
`default_nettype none
package htt_pkg;

	localparam int MAX_NODES_DEF = 256;
	localparam int NODE_W        = 10;
	localparam int COUNT_W       = 9;
	localparam int INDEX_W       = 8;
	localparam int SYM_W         = 8;
	localparam int BYTE_W        = 8;
	localparam int BIT_W         = 3;

	localparam logic [NODE_W-1:0] END_LEAF = 10'h2FF;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_DECODE = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_FLUSH,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic start;
		logic load;
		logic begin_byte;
		logic step;
		logic flush;
		logic push_err;
	} ctrl_cmd_t;

	typedef struct packed {
		logic count_bad;
		logic leaf;
		logic pend_valid;
		logic out_free;
		logic last_bit;
	} dp_status_t;

endpackage
`default_nettype wire

[rtl/htt_ctrl.sv]
// Controller state machine for the Huffman tree-table decoder.
`timescale 1ns / 1ps
`default_nettype none
module htt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         command,
	input  wire htt_pkg::dp_status_t st,
	output htt_pkg::ctrl_cmd_t      cmd
);
	import htt_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   advance;

	assign advance  = !(st.leaf && st.pend_valid && !st.out_free);
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (command)
						CMD_START: begin
							if (st.count_bad) begin
								state_d = ST_ERR;
							end
						end
						CMD_DECODE: begin
							state_d = ST_STEP;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_STEP: begin
				if (advance && st.last_bit) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!st.pend_valid || st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (command)
						CMD_START:  cmd.start      = !st.count_bad;
						CMD_LOAD:   cmd.load       = 1'b1;
						CMD_DECODE: cmd.begin_byte = 1'b1;
						default:    cmd            = '0;
					endcase
				end
			end
			ST_STEP:  cmd.step     = advance;
			ST_FLUSH: cmd.flush    = !st.pend_valid || st.out_free;
			ST_ERR:   cmd.push_err = st.out_free;
			default:  cmd          = '0;
		endcase
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.flush || cmd.push_err) |-> in_stall)
		else $error("work command issued while input open");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_err |=> !in_stall)
		else $error("error beat did not return to idle");

endmodule
`default_nettype wire

[rtl/htt_dp.sv]
// Datapath for the Huffman tree-table decoder: node table, tree walk, result registers.
`timescale 1ns / 1ps
`default_nettype none
module htt_dp #(
	parameter int MAX_NODES = htt_pkg::MAX_NODES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire htt_pkg::ctrl_cmd_t                cmd,
	output htt_pkg::dp_status_t                    st,
	input  wire logic [htt_pkg::COUNT_W-1:0]       node_count,
	input  wire logic [htt_pkg::INDEX_W-1:0]       node_index,
	input  wire logic signed [htt_pkg::NODE_W-1:0] left_child,
	input  wire logic signed [htt_pkg::NODE_W-1:0] right_child,
	input  wire logic [htt_pkg::BYTE_W-1:0]        data_byte,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [htt_pkg::SYM_W-1:0]              symbol,
	output logic                                   end_of_stream,
	output logic                                   error,
	output logic                                   last
);
	import htt_pkg::*;

	localparam int AW = $clog2(MAX_NODES);
	localparam logic [COUNT_W-1:0] MaxN = COUNT_W'(MAX_NODES);

	logic [2*NODE_W-1:0] mem [0:MAX_NODES-1];
	logic [2*NODE_W-1:0] rd_q;
	logic                root_hit_q;
	logic                root_end_q;
	logic [AW-1:0]       cur_node_q;
	logic [COUNT_W-1:0]  loaded_count_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [BIT_W-1:0]    bit_q;

	logic                pend_valid_q;
	logic [SYM_W-1:0]    pend_sym_q;
	logic                pend_eos_q;

	logic                out_valid_q;
	logic [SYM_W-1:0]    out_sym_q;
	logic                out_eos_q;
	logic                out_err_q;
	logic                out_last_q;

	logic [2*NODE_W-1:0] entry;
	logic [NODE_W-1:0]   child;
	logic                leaf;
	logic [COUNT_W-1:0]  leaf_val;
	logic [SYM_W-1:0]    leaf_sym;
	logic                leaf_eos;
	logic [AW-1:0]       next_node;
	logic [AW-1:0]       rd_addr;
	logic                rd_en;
	logic                wr_en;
	logic                out_free;
	logic                push_mid;
	logic                push_last;

	assign entry     = root_hit_q ? {END_LEAF, END_LEAF} : rd_q;
	assign child     = byte_q[bit_q] ? entry[NODE_W-1:0] : entry[2*NODE_W-1:NODE_W];
	assign leaf      = child[NODE_W-1];
	assign leaf_val  = ~child[COUNT_W-1:0];
	assign leaf_eos  = leaf_val[COUNT_W-1];
	assign leaf_sym  = leaf_eos ? '0 : leaf_val[SYM_W-1:0];
	assign next_node = (!leaf && (child[COUNT_W-1:0] < MaxN)) ? child[AW-1:0] : '0;

	assign rd_en   = cmd.begin_byte || cmd.step;
	assign rd_addr = cmd.begin_byte ? cur_node_q : next_node;
	assign wr_en   = cmd.load && ({1'b0, node_index} < loaded_count_q)
		&& ({1'b0, node_index} < MaxN);

	assign out_free  = !out_valid_q || !out_stall;
	assign push_mid  = cmd.step && leaf && pend_valid_q;
	assign push_last = cmd.flush && pend_valid_q;

	assign st.count_bad  = node_count > MaxN;
	assign st.leaf       = leaf;
	assign st.pend_valid = pend_valid_q;
	assign st.out_free   = out_free;
	assign st.last_bit   = (bit_q == '1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[node_index[AW-1:0]] <= {left_child, right_child};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			root_hit_q <= (rd_addr == '0) && root_end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_end_q     <= 1'b1;
			cur_node_q     <= '0;
			loaded_count_q <= '0;
		end else begin
			if (cmd.start) begin
				root_end_q     <= 1'b1;
				cur_node_q     <= '0;
				loaded_count_q <= node_count;
			end else if (wr_en && (node_index == '0)) begin
				root_end_q <= 1'b0;
			end
			if (cmd.step) begin
				cur_node_q <= next_node;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.begin_byte) begin
			byte_q <= data_byte;
			bit_q  <= '0;
		end else if (cmd.step) begin
			bit_q <= bit_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.step && leaf) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (push_mid || push_last || cmd.push_err) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && leaf) begin
			pend_sym_q <= leaf_sym;
			pend_eos_q <= leaf_eos;
		end
		if (push_mid || push_last) begin
			out_sym_q  <= pend_sym_q;
			out_eos_q  <= pend_eos_q;
			out_err_q  <= 1'b0;
			out_last_q <= push_last;
		end else if (cmd.push_err) begin
			out_sym_q  <= '0;
			out_eos_q  <= 1'b0;
			out_err_q  <= 1'b1;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign symbol        = out_sym_q;
	assign end_of_stream = out_eos_q;
	assign error         = out_err_q;
	assign last          = out_last_q;

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_mid || push_last || cmd.push_err) |-> out_free)
		else $error("result pushed into a held output beat");
	a_node_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(cur_node_q) < MAX_NODES))
		else $error("walk node outside table");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(loaded_count_q <= MaxN))
		else $error("node count above table size");
	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> !pend_valid_q)
		else $error("pending symbol survived flush");
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> (out_last_q && !out_eos_q && (out_sym_q == '0)))
		else $error("malformed error beat");

endmodule
`default_nettype wire

[rtl/huffman_tree_table_decoder.sv]
// Top level of the Huffman tree-table decoder.
// Usage:
//   Input channel (in_valid/in_stall) takes one command beat: start a stream
//   with node_count, load one tree node (node_index, left_child, right_child),
//   or decode data_byte. A child below zero is a leaf for symbol -(child+1).
//   Output channel (out_valid/out_stall) gives symbol, end_of_stream, error
//   and last; last marks the final beat caused by one input beat.
//   Load beats and start beats with a good count are accepted back to back.
//   A bad start count gives an error beat with last once the output is free.
//   A data byte is walked in order: the accept cycle reads the current node,
//   then each bit steps through the single node-table read port (the
//   next node address feeds the registered read), then a flush step pushes
//   the held symbol with its last flag. A symbol is held until the next
//   leaf or the flush and is registered onto the output in the cycle after.
//   A stalled output holds its beat; the walk pauses only when a second
//   symbol needs the output slot, and in_stall stays high until done.
//   Reset clears the walk to the root, the node count to zero, and makes
//   node 0 an end-of-stream pair; other node entries are undefined.
`timescale 1ns / 1ps
`default_nettype none
module huffman_tree_table_decoder #(
	parameter int MAX_NODES = htt_pkg::MAX_NODES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        command,
	input  wire logic [htt_pkg::COUNT_W-1:0]       node_count,
	input  wire logic [htt_pkg::INDEX_W-1:0]       node_index,
	input  wire logic signed [htt_pkg::NODE_W-1:0] left_child,
	input  wire logic signed [htt_pkg::NODE_W-1:0] right_child,
	input  wire logic [htt_pkg::BYTE_W-1:0]        data_byte,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [htt_pkg::SYM_W-1:0]              symbol,
	output logic                                   end_of_stream,
	output logic                                   error,
	output logic                                   last
);
	import htt_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t st;

	htt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.st       (st),
		.cmd      (cmd)
	);

	htt_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.node_count    (node_count),
		.node_index    (node_index),
		.left_child    (left_child),
		.right_child   (right_child),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.symbol        (symbol),
		.end_of_stream (end_of_stream),
		.error         (error),
		.last          (last)
	);

endmodule
`default_nettype wire
